/* src/ppe_pkg.sv */
// Package for the particle pool engine: pool constants, item kinds, states,
// slot record layout and fixed-point helpers. No dependencies.
package ppe_pkg;

    localparam int POOL_SIZE  = 64;
    localparam int POOL_W     = $clog2(POOL_SIZE);
    localparam int DT_MAX     = 205;
    localparam int ALPHA_FULL = 225;

    typedef enum logic [1:0] {
        KIND_SPAWN  = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_RENDER = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SPAWN_WR,
        ST_T_RD,
        ST_T_M1,
        ST_T_M2,
        ST_T_M3,
        ST_T_WB,
        ST_R_LAST,
        ST_R_RD,
        ST_R_SET,
        ST_R_DIVS,
        ST_R_SETA,
        ST_R_DIVA,
        ST_R_OUT
    } t_state;

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [23:0] grav;
        logic [15:0]        life;
        logic [15:0]        max_life;
        logic [15:0]        size0;
        logic [15:0]        size1;
        logic [23:0]        rgb;
        logic               add;
    } t_slot;

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        logic signed [23:0] r;
        if (v < -26'sd8388608) begin
            r = 24'sh800000;
        end else if (v > 26'sd8388607) begin
            r = 24'sh7FFFFF;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    // (2*coord - size) / 512 toward zero, saturated to 16 bits
    function automatic logic [15:0] rect_edge(input logic signed [23:0] c,
                                              input logic [15:0] sz);
        logic signed [25:0] v;
        logic signed [25:0] adj;
        logic signed [25:0] e;
        logic [15:0]        r;
        v   = ($signed({c[23], c[23], c}) <<< 1) - $signed({10'd0, sz});
        adj = (v < 0) ? v + 26'sd511 : v;
        e   = adj >>> 9;
        if (e < -26'sd32768) begin
            r = 16'h8000;
        end else if (e > 26'sd32767) begin
            r = 16'h7FFF;
        end else begin
            r = e[15:0];
        end
        return r;
    endfunction

endpackage

/* src/particle_pool_engine.sv */
// Particle pool engine top level: allocator, tick integrator and renderer
// around one slot memory. Depends on ppe_pkg.
//
// Items are taken one at a time. Spawn, when enabled, scans the live flags
// from the rotating pointer, one slot a cycle, then writes the slot. Tick
// walks every slot, skipping dead slots and taking each live slot through
// read, two multiplies with a velocity update between, and write back.
// Render first scans the live flags for the final slot, then per live slot
// reads the memory and runs a shift-subtract divider for a 16-bit quotient
// twice (size, then alpha); a slot spawned with zero lifetime skips both
// divisions. Clear drops every live flag. A finished result waits in the
// output register while the next item is accepted.
module particle_pool_engine (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, vel_x, vel_y, gravity, lifetime, size_start, size_end,
    // color_rgb, additive, time_step, zero pad
    input  logic [215:0] s_axis_tdata,
    // kind
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rect_x, rect_y, rect_size, alpha, tint, blend_add, zero pad
    output logic [79:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_data
);

    localparam int PW = ppe_pkg::POOL_W;
    localparam logic [PW-1:0] LAST_SLOT = PW'(ppe_pkg::POOL_SIZE - 1);

    ppe_pkg::t_slot mem [ppe_pkg::POOL_SIZE];

    ppe_pkg::t_state r_state, n_state;
    logic [PW-1:0]   r_idx, n_idx, r_cnt, n_cnt, r_next, n_next, r_last, n_last;
    logic            r_any, n_any;
    logic [ppe_pkg::POOL_SIZE-1:0] r_alive, n_alive;
    logic            r_enabled;
    ppe_pkg::t_slot  r_item, n_item;
    logic [7:0]      r_dt, n_dt;
    ppe_pkg::t_slot  r_rd;
    logic signed [32:0] r_gv, n_gv, r_vxd, n_vxd, r_vyd, n_vyd;
    logic signed [23:0] r_vy, n_vy;
    logic [15:0]     r_rem, n_rem, r_low, n_low, r_q, n_q, r_sz, n_sz;
    logic [3:0]      r_dcnt, n_dcnt;
    logic [7:0]      r_alpha, n_alpha;
    logic            r_ovalid, n_ovalid, r_olast, n_olast;
    logic [79:0]     r_odata, n_odata;

    logic            rd_en, we;
    ppe_pkg::t_slot  wdata;
    logic [PW-1:0]   idx_inc;
    logic [16:0]     dv_t;
    logic            dv_ge;
    logic [31:0]     num;
    logic [15:0]     life_left;
    logic signed [25:0] px_sum, py_sum, vy_sum;
    logic [15:0]     ts;

    assign s_axis_tready = (r_state == ppe_pkg::ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    assign idx_inc = (r_idx == LAST_SLOT) ? '0 : r_idx + 1'b1;
    assign dv_t    = {r_rem, r_low[15]};
    assign dv_ge   = dv_t >= {1'b0, r_rd.max_life};
    assign ts      = s_axis_tdata[208:193];

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_next   = r_next;
        n_last   = r_last;
        n_any    = r_any;
        n_alive  = r_alive;
        n_item   = r_item;
        n_dt     = r_dt;
        n_gv     = r_gv;
        n_vxd    = r_vxd;
        n_vyd    = r_vyd;
        n_vy     = r_vy;
        n_rem    = r_rem;
        n_low    = r_low;
        n_q      = r_q;
        n_sz     = r_sz;
        n_dcnt   = r_dcnt;
        n_alpha  = r_alpha;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_olast  = r_olast;
        n_odata  = r_odata;
        rd_en    = 1'b0;
        we       = 1'b0;
        wdata    = r_rd;
        num      = '0;
        vy_sum   = 26'($signed({r_rd.vy[23], r_rd.vy[23], r_rd.vy}) + (r_gv >>> 12));
        px_sum   = 26'($signed({r_rd.px[23], r_rd.px[23], r_rd.px}) + (r_vxd >>> 12));
        py_sum   = 26'($signed({r_rd.py[23], r_rd.py[23], r_rd.py}) + (r_vyd >>> 12));
        life_left = r_rd.life - {8'd0, r_dt};

        unique case (r_state)
            ppe_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_item.px       = s_axis_tdata[23:0];
                    n_item.py       = s_axis_tdata[47:24];
                    n_item.vx       = s_axis_tdata[71:48];
                    n_item.vy       = s_axis_tdata[95:72];
                    n_item.grav     = s_axis_tdata[119:96];
                    n_item.life     = s_axis_tdata[135:120];
                    n_item.max_life = s_axis_tdata[135:120];
                    n_item.size0    = s_axis_tdata[151:136];
                    n_item.size1    = s_axis_tdata[167:152];
                    n_item.rgb      = s_axis_tdata[191:168];
                    n_item.add      = s_axis_tdata[192];
                    n_dt = (ts > 16'(ppe_pkg::DT_MAX)) ? 8'(ppe_pkg::DT_MAX) : ts[7:0];
                    unique case (ppe_pkg::t_kind'(s_axis_tuser))
                        ppe_pkg::KIND_SPAWN: begin
                            if (r_enabled) begin
                                n_idx   = r_next;
                                n_cnt   = '0;
                                n_state = ppe_pkg::ST_SCAN;
                            end
                        end
                        ppe_pkg::KIND_TICK: begin
                            n_idx   = '0;
                            n_state = ppe_pkg::ST_T_RD;
                        end
                        ppe_pkg::KIND_RENDER: begin
                            n_idx   = '0;
                            n_any   = 1'b0;
                            n_state = ppe_pkg::ST_R_LAST;
                        end
                        ppe_pkg::KIND_CLEAR: begin
                            n_alive = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ppe_pkg::ST_SCAN: begin
                if (!r_alive[r_idx]) begin
                    n_state = ppe_pkg::ST_SPAWN_WR;
                end else if (r_cnt == LAST_SLOT) begin
                    n_idx   = r_next;
                    n_state = ppe_pkg::ST_SPAWN_WR;
                end else begin
                    n_idx = idx_inc;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ppe_pkg::ST_SPAWN_WR: begin
                we             = 1'b1;
                wdata          = r_item;
                n_alive[r_idx] = 1'b1;
                n_next         = idx_inc;
                n_state        = ppe_pkg::ST_IDLE;
            end
            ppe_pkg::ST_T_RD: begin
                if (r_alive[r_idx]) begin
                    rd_en   = 1'b1;
                    n_state = ppe_pkg::ST_T_M1;
                end else if (r_idx == LAST_SLOT) begin
                    n_state = ppe_pkg::ST_IDLE;
                end else begin
                    n_idx = idx_inc;
                end
            end
            ppe_pkg::ST_T_M1: begin
                n_gv    = 33'(r_rd.grav) * 33'($signed({1'b0, r_dt}));
                n_vxd   = 33'(r_rd.vx) * 33'($signed({1'b0, r_dt}));
                n_state = ppe_pkg::ST_T_M2;
            end
            ppe_pkg::ST_T_M2: begin
                n_vy    = ppe_pkg::sat24(vy_sum);
                n_state = ppe_pkg::ST_T_M3;
            end
            ppe_pkg::ST_T_M3: begin
                n_vyd   = 33'(r_vy) * 33'($signed({1'b0, r_dt}));
                n_state = ppe_pkg::ST_T_WB;
            end
            ppe_pkg::ST_T_WB: begin
                we       = 1'b1;
                wdata.vy = r_vy;
                wdata.px = ppe_pkg::sat24(px_sum);
                wdata.py = ppe_pkg::sat24(py_sum);
                if ({8'd0, r_dt} >= r_rd.life) begin
                    wdata.life     = '0;
                    n_alive[r_idx] = 1'b0;
                end else begin
                    wdata.life = life_left;
                end
                if (r_idx == LAST_SLOT) begin
                    n_state = ppe_pkg::ST_IDLE;
                end else begin
                    n_idx   = idx_inc;
                    n_state = ppe_pkg::ST_T_RD;
                end
            end
            ppe_pkg::ST_R_LAST: begin
                if (r_alive[r_idx]) begin
                    n_last = r_idx;
                    n_any  = 1'b1;
                end
                if (r_idx == LAST_SLOT) begin
                    n_idx   = '0;
                    n_state = (n_any) ? ppe_pkg::ST_R_RD : ppe_pkg::ST_IDLE;
                end else begin
                    n_idx = idx_inc;
                end
            end
            ppe_pkg::ST_R_RD: begin
                if (r_alive[r_idx]) begin
                    rd_en   = 1'b1;
                    n_state = ppe_pkg::ST_R_SET;
                end else begin
                    n_idx = idx_inc;
                end
            end
            ppe_pkg::ST_R_SET: begin
                if (r_rd.max_life == '0) begin
                    n_sz    = r_rd.size1;
                    n_alpha = '0;
                    n_state = ppe_pkg::ST_R_OUT;
                end else begin
                    num = 32'(r_rd.size1) * 32'(r_rd.max_life - r_rd.life)
                        + 32'(r_rd.size0) * 32'(r_rd.life);
                    n_rem   = num[31:16];
                    n_low   = num[15:0];
                    n_dcnt  = 4'd15;
                    n_state = ppe_pkg::ST_R_DIVS;
                end
            end
            ppe_pkg::ST_R_DIVS, ppe_pkg::ST_R_DIVA: begin
                n_rem  = dv_ge ? 16'(dv_t - {1'b0, r_rd.max_life}) : dv_t[15:0];
                n_low  = {r_low[14:0], 1'b0};
                n_q    = {r_q[14:0], dv_ge};
                n_dcnt = r_dcnt - 1'b1;
                if (r_dcnt == '0) begin
                    if (r_state == ppe_pkg::ST_R_DIVS) begin
                        n_sz    = n_q;
                        n_state = ppe_pkg::ST_R_SETA;
                    end else begin
                        n_alpha = n_q[7:0];
                        n_state = ppe_pkg::ST_R_OUT;
                    end
                end
            end
            ppe_pkg::ST_R_SETA: begin
                num     = 32'(r_rd.life) * 32'(ppe_pkg::ALPHA_FULL);
                n_rem   = num[31:16];
                n_low   = num[15:0];
                n_dcnt  = 4'd15;
                n_state = ppe_pkg::ST_R_DIVA;
            end
            ppe_pkg::ST_R_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_olast  = (r_idx == r_last);
                    n_odata  = {7'd0, r_rd.add, r_rd.rgb, r_alpha, r_sz[15:8],
                                ppe_pkg::rect_edge(r_rd.py, r_sz),
                                ppe_pkg::rect_edge(r_rd.px, r_sz)};
                    if (r_idx == r_last) begin
                        n_state = ppe_pkg::ST_IDLE;
                    end else begin
                        n_idx   = idx_inc;
                        n_state = ppe_pkg::ST_R_RD;
                    end
                end
            end
            default: n_state = ppe_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ppe_pkg::ST_IDLE;
            r_next    <= '0;
            r_alive   <= '0;
            r_enabled <= 1'b1;
            r_ovalid  <= 1'b0;
            r_any     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_next   <= n_next;
            r_alive  <= n_alive;
            r_ovalid <= n_ovalid;
            r_any    <= n_any;
            if (i_cfg_valid) begin
                r_enabled <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_cnt   <= n_cnt;
        r_last  <= n_last;
        r_item  <= n_item;
        r_dt    <= n_dt;
        r_gv    <= n_gv;
        r_vxd   <= n_vxd;
        r_vyd   <= n_vyd;
        r_vy    <= n_vy;
        r_rem   <= n_rem;
        r_low   <= n_low;
        r_q     <= n_q;
        r_sz    <= n_sz;
        r_dcnt  <= n_dcnt;
        r_alpha <= n_alpha;
        r_olast <= n_olast;
        r_odata <= n_odata;
    end

    // slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_idx] <= wdata;
        end
        if (rd_en) begin
            r_rd <= mem[r_idx];
        end
    end

endmodule
